// ===== src/rast_pkg.sv =====
// Shared constants for the range-add / range-sum store.
package rast_pkg;

	// Entries in the store, indexed 1..NUM_ENTRIES
	localparam int NUM_ENTRIES = 1024;
	localparam int ADDR_W      = $clog2(NUM_ENTRIES);
	// Walk index: holds up to 2*NUM_ENTRIES during an upward walk
	localparam int IDX_W       = ADDR_W + 2;
	// Field widths fixed by the ports
	localparam int POS_W       = 11;
	localparam int ADD_W       = 32;
	localparam int VAL_W       = 64;
	// One memory word holds both Fenwick arrays: {coef, bias}
	localparam int WORD_W      = 2 * VAL_W;

	localparam logic [POS_W-1:0] ACTIVE_RESET = POS_W'(1024);

	// Item actions
	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

endpackage

// ===== src/rast_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rast_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/range_add_range_sum_tree.sv =====
// Range-add / range-sum store built on two Fenwick arrays kept in one RAM.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------
//  in      | in_valid / in_stall       | action, range_low, range_high, addend
//  out     | out_valid / out_stall     | range_sum, bad_range
//  cfg     | cfg_valid / cfg_ready     | active_entries
//
// An add runs two upward walks of up to log2(N)+1 reads each. A query runs two
// downward walks, each followed by a multiply step and an accumulate step.
// Each walk step is one read of the RAM port; an add also writes the word back.
// After reset a clearing pass writes zero to all N words (1024 here); no item is
// taken during it, configuration is.
// A finished result waits in the output register while the next item is taken;
// a query stalls in its last state only when that register is still full.
module range_add_range_sum_tree (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic [rast_pkg::POS_W-1:0]      range_low,
	input  logic [rast_pkg::POS_W-1:0]      range_high,
	input  logic signed [rast_pkg::ADD_W-1:0] addend,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [rast_pkg::VAL_W-1:0] range_sum,
	output logic                            bad_range,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rast_pkg::POS_W-1:0]      active_entries
);
	import rast_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_PREP, S_WALK, S_MUL, S_ACC, S_OUT
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic [POS_W-1:0]    active_q;
	logic                out_valid_q;
	logic [VAL_W-1:0]    range_sum_q;
	logic                bad_range_q;

	// Item registers
	logic                op_add_q;
	logic                bad_q;
	logic [POS_W-1:0]    lo_q;
	logic [POS_W-1:0]    hi_q;
	logic [VAL_W-1:0]    addend_q;
	logic [VAL_W-1:0]    prod_lo_q;
	logic [VAL_W-1:0]    prod_hi_q;

	// Walk registers
	logic                job_q;
	logic [IDX_W-1:0]    idx_q;
	logic [VAL_W-1:0]    d1_q;
	logic [VAL_W-1:0]    d2_q;
	logic [POS_W-1:0]    weight_q;
	logic [VAL_W-1:0]    acc1_q;
	logic [VAL_W-1:0]    total_q;
	logic [VAL_W-1:0]    prod_q;

	// Memory pipeline
	logic                rd_v_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                wr_v_q;
	logic [ADDR_W-1:0]   wr_addr_q;
	logic [WORD_W-1:0]   wr_data_q;

	logic                accept;
	logic [POS_W-1:0]    limit;
	logic                bad_in;
	logic [POS_W-1:0]    lo_m1_in;
	logic signed [ADD_W+POS_W:0] mul_lo;
	logic signed [ADD_W+POS_W:0] mul_hi;
	logic [IDX_W-1:0]    lowbit;
	logic [IDX_W-1:0]    idx_m1;
	logic                idx_ok;
	logic                issue;
	logic [WORD_W-1:0]   rd_data;
	logic [WORD_W-1:0]   base;
	logic [WORD_W-1:0]   upd;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic                out_free;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign range_sum = $signed(range_sum_q);
	assign bad_range = bad_range_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Range check against the effective limit
	assign limit    = (active_q > POS_W'(NUM_ENTRIES)) ? POS_W'(NUM_ENTRIES) : active_q;
	assign bad_in   = (range_low == '0) || (range_low > range_high) || (range_high > limit);
	assign lo_m1_in = range_low - POS_W'(1);
	assign mul_lo   = addend * $signed({1'b0, lo_m1_in});
	assign mul_hi   = addend * $signed({1'b0, range_high});

	// Walk step: lowest set bit of the index
	assign lowbit = idx_q & (~idx_q + IDX_W'(1));
	assign idx_m1 = idx_q - IDX_W'(1);
	assign idx_ok = (idx_q != '0) && (idx_q <= IDX_W'(NUM_ENTRIES));
	assign issue  = (state_q == S_WALK) && idx_ok;

	// Forward the word written last cycle into a read of the same entry
	assign base = (wr_v_q && (wr_addr_q == addr_s1)) ? wr_data_q : rd_data;
	assign upd  = {base[WORD_W-1:VAL_W] + d1_q, base[VAL_W-1:0] + d2_q};

	assign ram_we    = (state_q == S_CLEAR) || (rd_v_s1 && op_add_q);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_cnt_q : addr_s1;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : upd;

	rast_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_m1[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	// Hold the active-entries register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= active_entries;
		end
	end

	// Track reads in flight and the last write for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			wr_v_q  <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			wr_v_q  <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= idx_m1[ADDR_W-1:0];
		wr_addr_q <= ram_waddr;
		wr_data_q <= ram_wdata;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			range_sum_q <= '0;
			bad_range_q <= 1'b0;
		end else begin
			// Drop a transferred result; the output state refills it itself
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == ADDR_W'(NUM_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (bad_q) begin
						state_q <= op_add_q ? S_IDLE : S_OUT;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!idx_ok) begin
						if (!op_add_q) begin
							state_q <= S_MUL;
						end else if (job_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= job_q ? S_OUT : S_WALK;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						range_sum_q <= total_q;
						bad_range_q <= bad_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item capture, walk control and accumulation
	always_ff @(posedge clk) begin
		if (accept) begin
			op_add_q  <= (action == ACT_ADD);
			bad_q     <= bad_in;
			lo_q      <= range_low;
			hi_q      <= range_high;
			addend_q  <= VAL_W'(addend);
			prod_lo_q <= VAL_W'(mul_lo);
			prod_hi_q <= VAL_W'(mul_hi);
		end

		// Sum data arriving from a query read
		if (rd_v_s1 && !op_add_q) begin
			acc1_q <= acc1_q + rd_data[WORD_W-1:VAL_W];
			total_q <= job_q ? total_q + rd_data[VAL_W-1:0]
			                 : total_q - rd_data[VAL_W-1:0];
		end

		case (state_q)
			S_PREP: begin
				job_q   <= 1'b0;
				acc1_q  <= '0;
				total_q <= '0;
				d1_q    <= addend_q;
				d2_q    <= prod_lo_q;
				idx_q   <= op_add_q ? IDX_W'(lo_q) : IDX_W'(hi_q);
				weight_q <= hi_q;
			end
			S_WALK: begin
				if (idx_ok) begin
					idx_q <= op_add_q ? idx_q + lowbit : idx_q - lowbit;
				end else if (op_add_q && !job_q) begin
					// Second point update at high+1 with negated deltas
					job_q <= 1'b1;
					idx_q <= IDX_W'(hi_q) + IDX_W'(1);
					d1_q  <= '0 - addend_q;
					d2_q  <= '0 - prod_hi_q;
				end
			end
			S_MUL: begin
				prod_q <= acc1_q * VAL_W'(weight_q);
			end
			S_ACC: begin
				total_q <= job_q ? total_q - prod_q : total_q + prod_q;
				if (!job_q) begin
					job_q    <= 1'b1;
					acc1_q   <= '0;
					idx_q    <= IDX_W'(lo_q) - IDX_W'(1);
					weight_q <= lo_q - POS_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_PREP))
		else $error("accepted item did not enter prep");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_range) |-> (range_sum == '0))
		else $error("bad range with nonzero sum");

	a_mul_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> !rd_v_s1)
		else $error("multiply started with a read in flight");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result shown outside the output state");
`endif

endmodule
